@@ design/sctp_cw_pkg.sv @@
package sctp_cw_pkg;

	// Common header length and smallest legal chunk length.
	localparam logic [15:0] HDR_LEN   = 16'd12;
	localparam logic [15:0] MIN_CHUNK = 16'd4;

	// Only chunks with an index below this value set the SHUTDOWN flag.
	localparam logic [7:0] MAX_TRACKED = 8'd16;

	// Chunk lengths are padded up to a multiple of four.
	localparam logic [16:0] PAD_ADD = 17'd3;

	// Chunk type codes that are tracked.
	localparam logic [7:0] CT_DATA     = 8'd0;
	localparam logic [7:0] CT_INIT     = 8'd1;
	localparam logic [7:0] CT_INIT_ACK = 8'd2;
	localparam logic [7:0] CT_ABORT    = 8'd6;
	localparam logic [7:0] CT_SHUTDOWN = 8'd7;

	// Bit positions in the type flags.
	localparam int TF_INIT     = 0;
	localparam int TF_INIT_ACK = 1;
	localparam int TF_DATA     = 2;
	localparam int TF_ABORT    = 3;
	localparam int TF_SHUTDOWN = 4;

	// Bit positions in the event flags.
	localparam int EV_INIT_TAG  = 0;
	localparam int EV_DATA_TAG  = 1;
	localparam int EV_NOT_ALONE = 2;

	// Packet status codes.
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_SHORT  = 2'd1,
		ST_TRUNC  = 2'd2,
		ST_BADLEN = 2'd3
	} status_t;

	// Position inside a chunk header.
	typedef enum logic [3:0] {
		HP_TYPE   = 4'b0001,
		HP_FLAGS  = 4'b0010,
		HP_LEN_HI = 4'b0100,
		HP_LEN_LO = 4'b1000
	} hpos_t;

	// One result item.
	typedef struct packed {
		logic        is_summary;
		logic [7:0]  chunk_type;
		logic [7:0]  chunk_index;
		logic [15:0] chunk_length;
		status_t     status;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] header_len;
		logic [7:0]  chunk_count;
		logic [4:0]  type_flags;
		logic [2:0]  event_flags;
	} res_t;

endpackage

@@ design/sctp_cw_if.sv @@
// Byte stream channel.
interface sctp_cw_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic [15:0] packet_len;
	logic        last_byte;

	modport source (output valid, output data_byte, output packet_len, output last_byte,
		input ready);
	modport sink (input valid, input data_byte, input packet_len, input last_byte,
		output ready);
endinterface

// Result channel.
interface sctp_cw_out_if;
	logic        valid;
	logic        ready;
	logic        is_summary;
	logic [7:0]  chunk_type;
	logic [7:0]  chunk_index;
	logic [15:0] chunk_length;
	logic [1:0]  status;
	logic [15:0] src_port;
	logic [15:0] dst_port;
	logic [15:0] header_len;
	logic [7:0]  chunk_count;
	logic [4:0]  type_flags;
	logic [2:0]  event_flags;

	modport source (output valid, output is_summary, output chunk_type, output chunk_index,
		output chunk_length, output status, output src_port, output dst_port,
		output header_len, output chunk_count, output type_flags, output event_flags,
		input ready);
	modport sink (input valid, input is_summary, input chunk_type, input chunk_index,
		input chunk_length, input status, input src_port, input dst_port,
		input header_len, input chunk_count, input type_flags, input event_flags,
		output ready);
endinterface

@@ design/sctp_cw_fifo.sv @@
// Shifting result queue: the head is always entry 0, up to two entries enter per cycle.
module sctp_cw_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         push_cnt,
	input  sctp_cw_pkg::res_t  push0,
	input  sctp_cw_pkg::res_t  push1,
	input  logic               pop,
	output sctp_cw_pkg::res_t  head,
	output logic               head_valid,
	output logic               room2
);
	import sctp_cw_pkg::*;

	localparam int unsigned LW = $clog2(DEPTH + 1);

	logic [LW-1:0] level_q;
	logic [LW-1:0] base_lvl;
	res_t          ent_q [DEPTH];
	res_t          ent_d [DEPTH];

	// Level after the pop, which is where new entries land.
	assign base_lvl = level_q - LW'(pop);

	// Shift on a pop, then write the pushed results behind the remaining ones.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ent_d[i] = ent_q[i];
		end
		if (pop) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				ent_d[i] = ent_q[i + 1];
			end
		end
		for (int i = 0; i < DEPTH; i++) begin
			if (push_cnt != 2'd0 && LW'(i) == base_lvl) begin
				ent_d[i] = push0;
			end
			if (push_cnt == 2'd2 && LW'(i) == base_lvl + LW'(1)) begin
				ent_d[i] = push1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			ent_q[i] <= ent_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else begin
			level_q <= base_lvl + LW'(push_cnt);
		end
	end

	assign head       = ent_q[0];
	assign head_valid = level_q != '0;
	assign room2      = level_q <= LW'(DEPTH - 2);

endmodule

@@ design/sctp_chunk_walker.sv @@
// SCTP chunk walker.
// The pkt channel carries one packet byte per transfer, common header first, with the
// total packet length and a mark on the final byte. The rec channel returns results:
// one chunk record for every valid chunk, issued on the transfer of its last length
// byte, and one packet summary issued on the transfer of the last byte. A byte that
// ends a chunk and the packet at once yields the record first, then the summary.
// Each byte is processed in the cycle of its transfer and its results are written to
// the queue that feeds the rec port. Throughput is one byte per cycle while pkt.ready
// is high; results leave at one per cycle while rec.ready is high.
// Results wait in a queue of FIFO_DEPTH entries (at least 2). pkt.ready stays high
// while the queue has room for two results, so a stalled receiver fills the queue and
// then holds off new bytes without losing any result.
// Reset empties the queue and clears all walk state; every summary clears it again
// for the next packet.
module sctp_chunk_walker #(
	parameter int unsigned FIFO_DEPTH = 4
) (
	input logic         clk,
	input logic         arst_n,
	sctp_cw_in_if.sink  pkt,
	sctp_cw_out_if.source rec
);
	import sctp_cw_pkg::*;

	// Walk state.
	logic [15:0] byte_offset_q,   byte_offset_d;
	logic [16:0] next_start_q,    next_start_d;
	hpos_t       hpos_q,          hpos_d;
	logic [7:0]  cur_type_q,      cur_type_d;
	logic [15:0] cur_len_q,       cur_len_d;
	logic [15:0] src_port_q,      src_port_d;
	logic [15:0] dst_port_q,      dst_port_d;
	logic [31:0] vtag_q,          vtag_d;
	logic [7:0]  valid_chunks_q,  valid_chunks_d;
	logic [4:0]  seen_types_q,    seen_types_d;
	logic [2:0]  events_q,        events_d;
	status_t     fatal_q,         fatal_d;

	logic        pkt_xfer;
	logic        walk_en;
	logic [15:0] rel;
	logic [15:0] clen;
	logic [17:0] chunk_end;
	logic        rec_vld;
	res_t        chunk_rec;
	res_t        summ_rec;
	status_t     st;
	logic [16:0] walked;
	logic [1:0]  push_cnt;
	res_t        push0;
	res_t        head;
	logic        head_valid;
	logic        room2;
	logic        pop;

	assign pkt_xfer = pkt.valid && pkt.ready;
	assign rel      = byte_offset_q - HDR_LEN;
	assign clen     = {cur_len_q[15:8], pkt.data_byte};
	assign chunk_end = {2'b0, HDR_LEN} + {1'b0, next_start_q} + {2'b0, clen};
	assign walk_en  = fatal_q == ST_OK && pkt.packet_len >= HDR_LEN
		&& byte_offset_q >= HDR_LEN && byte_offset_q < pkt.packet_len;

	// Header capture and chunk walk for one byte.
	always_comb begin
		byte_offset_d  = byte_offset_q;
		next_start_d   = next_start_q;
		hpos_d         = hpos_q;
		cur_type_d     = cur_type_q;
		cur_len_d      = cur_len_q;
		src_port_d     = src_port_q;
		dst_port_d     = dst_port_q;
		vtag_d         = vtag_q;
		valid_chunks_d = valid_chunks_q;
		seen_types_d   = seen_types_q;
		events_d       = events_q;
		fatal_d        = fatal_q;
		rec_vld        = 1'b0;

		if (byte_offset_q < 16'd2) begin
			src_port_d = {src_port_q[7:0], pkt.data_byte};
		end else if (byte_offset_q < 16'd4) begin
			dst_port_d = {dst_port_q[7:0], pkt.data_byte};
		end else if (byte_offset_q < 16'd8) begin
			vtag_d = {vtag_q[23:0], pkt.data_byte};
		end

		if (walk_en) begin
			unique case (hpos_q)
				HP_TYPE: begin
					if ({1'b0, rel} == next_start_q) begin
						if (pkt.packet_len - byte_offset_q < MIN_CHUNK) begin
							fatal_d = ST_TRUNC;
						end else begin
							cur_type_d = pkt.data_byte;
							hpos_d     = HP_FLAGS;
						end
					end
				end
				HP_FLAGS: begin
					hpos_d = HP_LEN_HI;
				end
				HP_LEN_HI: begin
					cur_len_d = {pkt.data_byte, 8'd0};
					hpos_d    = HP_LEN_LO;
				end
				HP_LEN_LO: begin
					cur_len_d = clen;
					hpos_d    = HP_TYPE;
					if (clen < MIN_CHUNK || chunk_end > {2'b0, pkt.packet_len}) begin
						fatal_d = ST_BADLEN;
					end else begin
						rec_vld = 1'b1;
						case (cur_type_q)
							CT_INIT: begin
								seen_types_d[TF_INIT] = 1'b1;
								if (vtag_q != 32'd0) events_d[EV_INIT_TAG] = 1'b1;
							end
							CT_INIT_ACK: seen_types_d[TF_INIT_ACK] = 1'b1;
							CT_DATA: begin
								seen_types_d[TF_DATA] = 1'b1;
								if (vtag_q == 32'd0) events_d[EV_DATA_TAG] = 1'b1;
							end
							CT_ABORT: seen_types_d[TF_ABORT] = 1'b1;
							CT_SHUTDOWN: begin
								if (valid_chunks_q < MAX_TRACKED) begin
									seen_types_d[TF_SHUTDOWN] = 1'b1;
								end
							end
							default: ;
						endcase
						if (valid_chunks_q != 8'hFF) valid_chunks_d = valid_chunks_q + 8'd1;
						next_start_d = next_start_q + (({1'b0, clen} + PAD_ADD) & ~PAD_ADD);
					end
				end
				default: hpos_d = HP_TYPE;
			endcase
		end

		if (byte_offset_q != 16'hFFFF) byte_offset_d = byte_offset_q + 16'd1;
	end

	// Chunk record for the chunk that ends on this byte.
	always_comb begin
		chunk_rec              = '0;
		chunk_rec.chunk_type   = cur_type_q;
		chunk_rec.chunk_index  = valid_chunks_q;
		chunk_rec.chunk_length = clen;
		chunk_rec.status       = ST_OK;
		chunk_rec.src_port     = src_port_d;
		chunk_rec.dst_port     = dst_port_d;
	end

	// Packet summary, judged from the state after this byte.
	assign walked = {1'b0, HDR_LEN} + next_start_d;

	always_comb begin
		if (pkt.packet_len < HDR_LEN || byte_offset_q < 16'd11) begin
			st = ST_SHORT;
		end else if (fatal_d != ST_OK) begin
			st = fatal_d;
		end else if (walked < {1'b0, pkt.packet_len}) begin
			st = ST_TRUNC;
		end else begin
			st = ST_OK;
		end

		summ_rec            = '0;
		summ_rec.is_summary = 1'b1;
		summ_rec.status     = st;
		summ_rec.event_flags = events_d;
		if (seen_types_d[TF_INIT_ACK:TF_INIT] != 2'b00 && valid_chunks_d > 8'd1) begin
			summ_rec.event_flags[EV_NOT_ALONE] = 1'b1;
		end
		if (st == ST_SHORT) begin
			summ_rec.event_flags = '0;
		end else begin
			summ_rec.src_port = src_port_d;
			summ_rec.dst_port = dst_port_d;
		end
		if (st == ST_OK) begin
			summ_rec.header_len  = (walked < {1'b0, pkt.packet_len}) ? walked[15:0]
				: pkt.packet_len;
			summ_rec.chunk_count = valid_chunks_d;
			summ_rec.type_flags  = seen_types_d;
		end
	end

	// State registers; a summary clears everything for the next packet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q  <= '0;
			next_start_q   <= '0;
			hpos_q         <= HP_TYPE;
			cur_type_q     <= '0;
			cur_len_q      <= '0;
			src_port_q     <= '0;
			dst_port_q     <= '0;
			vtag_q         <= '0;
			valid_chunks_q <= '0;
			seen_types_q   <= '0;
			events_q       <= '0;
			fatal_q        <= ST_OK;
		end else if (pkt_xfer) begin
			if (pkt.last_byte) begin
				byte_offset_q  <= '0;
				next_start_q   <= '0;
				hpos_q         <= HP_TYPE;
				cur_type_q     <= '0;
				cur_len_q      <= '0;
				src_port_q     <= '0;
				dst_port_q     <= '0;
				vtag_q         <= '0;
				valid_chunks_q <= '0;
				seen_types_q   <= '0;
				events_q       <= '0;
				fatal_q        <= ST_OK;
			end else begin
				byte_offset_q  <= byte_offset_d;
				next_start_q   <= next_start_d;
				hpos_q         <= hpos_d;
				cur_type_q     <= cur_type_d;
				cur_len_q      <= cur_len_d;
				src_port_q     <= src_port_d;
				dst_port_q     <= dst_port_d;
				vtag_q         <= vtag_d;
				valid_chunks_q <= valid_chunks_d;
				seen_types_q   <= seen_types_d;
				events_q       <= events_d;
				fatal_q        <= fatal_d;
			end
		end
	end

	// Results enter the queue in order: record first, then summary.
	assign push_cnt = pkt_xfer ? ({1'b0, rec_vld} + {1'b0, pkt.last_byte}) : 2'd0;
	assign push0    = rec_vld ? chunk_rec : summ_rec;
	assign pop      = head_valid && rec.ready;

	sctp_cw_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cnt   (push_cnt),
		.push0      (push0),
		.push1      (summ_rec),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.room2      (room2)
	);

	assign pkt.ready        = room2;
	assign rec.valid        = head_valid;
	assign rec.is_summary   = head.is_summary;
	assign rec.chunk_type   = head.chunk_type;
	assign rec.chunk_index  = head.chunk_index;
	assign rec.chunk_length = head.chunk_length;
	assign rec.status       = head.status;
	assign rec.src_port     = head.src_port;
	assign rec.dst_port     = head.dst_port;
	assign rec.header_len   = head.header_len;
	assign rec.chunk_count  = head.chunk_count;
	assign rec.type_flags   = head.type_flags;
	assign rec.event_flags  = head.event_flags;

	// A summary transfer restarts the walk at offset zero.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_xfer && pkt.last_byte |=> byte_offset_q == 16'd0 && fatal_q == ST_OK)
		else $error("walk state not cleared after last byte");

	// Inside a chunk header the walk cannot have failed.
	a_hdr_ok: assert property (@(posedge clk) disable iff (!arst_n)
		hpos_q != HP_TYPE |-> fatal_q == ST_OK)
		else $error("chunk header in progress after a fatal error");

	// Chunk starts stay on four-byte boundaries.
	a_align: assert property (@(posedge clk) disable iff (!arst_n)
		next_start_q[1:0] == 2'b00)
		else $error("next chunk start not aligned");

endmodule
